// ===== hdl/g2l_pkg.sv =====
`default_nettype none

package g2l_pkg;

    localparam int TABLE_YEARS = 199;
    localparam int FIRST_YEAR  = 1901;
    localparam int LAST_YEAR   = FIRST_YEAR + TABLE_YEARS - 1;
    localparam int ROW_W       = $clog2(TABLE_YEARS);

    typedef logic [23:0]      rom_word_t;
    typedef logic [ROW_W-1:0] row_t;

    // Per-year word: [23:20] leap month, [19:7] big/small flags of month
    // sequence 1..13, [6:5] spring festival month, [4:0] its day.
    localparam rom_word_t YEAR_ROM [TABLE_YEARS] = '{
        24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
        24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
        24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
        24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
        24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
        24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
        24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
        24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
        24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
        24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
        24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
        24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
        24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
        24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
        24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
        24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
        24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
        24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
        24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
        24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
        24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
        24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
        24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
        24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
        24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
        24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
        24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
        24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
        24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
        24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
        24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
        24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
        24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
        24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
        24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
        24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
        24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
        24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
        24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
    };

    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [4:0] LEN_BIG   = 5'd30;
    localparam logic [4:0] LEN_SMALL = 5'd29;

    typedef struct packed {
        logic       ok;
        logic [8:0] doy;
        row_t       row;
    } start_t;

    typedef struct packed {
        logic [3:0] mon;
        logic [4:0] day;
        logic       icl;
    } result_t;

    // length of the month at sequence index idx (1..13)
    function automatic logic [4:0] moon_len(input rom_word_t w, input logic [3:0] idx);
        logic [4:0] pos;
        rom_word_t  sh;
        pos = 5'd20 - {1'b0, idx};
        sh  = w >> pos;
        return sh[0] ? LEN_BIG : LEN_SMALL;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gregorian_to_chinese_lunar_date.sv =====
`default_nettype none

// Converts a Gregorian date (years 1901..2099) to the Chinese lunar month, day
// and an intercalary flag that is set only inside the leap month itself.
// Invalid dates, and dates of 1901 before its Spring Festival, give all-zero
// results; February 29 is accepted in every year (in a common year it counts as
// March 1). One date is converted at a time: the result is set by the month walk,
// which steps one lunar month per cycle through a year word held in a synchronous
// ROM (one read for dates on or after New Year, a second read of the previous
// year's word for dates before it). An invalid date goes straight to the result,
// a date of 1901 before New Year after the first read, a forward walk after that
// read and one step per month passed, a backward walk after both reads and one
// step per month passed, with at most 12 months passed. The next date is taken in
// the cycle after the result has moved to the output register.
module gregorian_to_chinese_lunar_date
    import g2l_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // greg_year[11:0], greg_month[15:12], greg_day[20:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // lunar_month[3:0], lunar_day[8:4], intercalary[9]
);

    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
    logic        year_ok, month_ok, day_ok;
    logic [4:0]  max_day;
    logic [3:0]  month_idx;
    logic [11:0] year_off;
    start_t      start_info;
    logic        start;
    logic        idle, done, out_free, load;
    result_t     result;
    row_t        rom_addr;
    rom_word_t   rom_q;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    assign greg_year  = s_tdata[11:0];
    assign greg_month = s_tdata[15:12];
    assign greg_day   = s_tdata[20:16];

    always_comb
    begin
        case (greg_month)
            4'd2:
            begin
                max_day = 5'd29;
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                max_day = 5'd30;
            end
            default:
            begin
                max_day = 5'd31;
            end
        endcase
    end

    assign year_ok   = (greg_year >= 12'(FIRST_YEAR)) && (greg_year <= 12'(LAST_YEAR));
    assign month_ok  = (greg_month >= 4'd1) && (greg_month <= 4'd12);
    assign day_ok    = (greg_day != 5'd0) && (greg_day <= max_day);
    assign month_idx = month_ok ? greg_month - 4'd1 : 4'd0;
    assign year_off  = greg_year - 12'(FIRST_YEAR);

    assign start_info.ok  = year_ok && month_ok && day_ok;
    assign start_info.row = year_off[ROW_W-1:0];
    assign start_info.doy = DAYS_BEFORE[month_idx] + {4'd0, greg_day} - 9'd1
                            + {8'd0, (greg_year[1:0] == 2'd0) && (greg_month > 4'd2)};

    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    g2l_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    g2l_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_info (start_info),
        .out_free   (out_free),
        .idle       (idle),
        .done       (done),
        .result     (result),
        .rom_addr   (rom_addr),
        .rom_q      (rom_q)
    );

    assign out_free      = !m_tvalid_reg || m_tready;
    assign load          = done && out_free;
    assign m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= {6'd0, result.icl, result.day, result.mon};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a conversion is in flight");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd12)
        else $error("lunar month out of range");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == 4'd0 |-> m_tdata[8:4] == 5'd0 && !m_tdata[9])
        else $error("partial result on invalid date");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_free |=> m_tvalid)
        else $error("result lost on output load");
`endif

endmodule

`default_nettype wire

// ===== hdl/g2l_rom.sv =====
`default_nettype none

module g2l_rom
    import g2l_pkg::*;
(
    input  wire logic      clk,
    input  wire row_t      addr,
    output rom_word_t      q
);

    rom_word_t q_reg;

    always_ff @(posedge clk)
    begin
        if (32'(addr) < TABLE_YEARS)
        begin
            q_reg <= YEAR_ROM[addr];
        end
        else
        begin
            q_reg <= '0;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== hdl/g2l_walk.sv =====
`default_nettype none

module g2l_walk
    import g2l_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire start_t  start_info,
    input  wire logic    out_free,
    output logic         idle,
    output logic         done,
    output result_t      result,
    output row_t         rom_addr,
    input  wire rom_word_t rom_q
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_RD_CUR  = 6'b000010,
        ST_RD_PREV = 6'b000100,
        ST_FWD     = 6'b001000,
        ST_BWD     = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    rom_word_t  w_reg, w_next;
    logic [8:0] rem_reg, rem_next;
    logic [3:0] idx_reg, idx_next;
    row_t       row_reg, row_next;
    logic [8:0] doy_reg, doy_next;
    result_t    res_reg, res_next;

    logic [5:0] spring;
    logic [8:0] doy1;
    logic [4:0] len;
    logic [3:0] months;
    logic [4:0] day_f;
    logic [8:0] day_b;

    // sequence index -> lunar month and intercalary flag
    function automatic result_t map_month(input rom_word_t w, input logic [3:0] idx,
                                          input logic [4:0] day);
        logic [3:0] lp;
        result_t    r;
        lp    = w[23:20];
        r.day = day;
        if (lp == 4'd0 || idx <= lp)
        begin
            r.mon = idx;
            r.icl = 1'b0;
        end
        else if ({1'b0, idx} == {1'b0, lp} + 5'd1)
        begin
            r.mon = lp;
            r.icl = 1'b1;
        end
        else
        begin
            r.mon = idx - 4'd1;
            r.icl = 1'b0;
        end
        return r;
    endfunction

    assign spring = (rom_q[6:5] == 2'd1) ? {1'b0, rom_q[4:0]}
                                         : {1'b0, rom_q[4:0]} + 6'd31;
    assign doy1   = doy_reg + 9'd1;
    assign len    = moon_len(w_reg, idx_reg);
    assign months = (w_reg[23:20] != 4'd0) ? 4'd13 : 4'd12;
    assign day_f  = rem_reg[4:0] + 5'd1;
    assign day_b  = {4'd0, len} - rem_reg + 9'd1;

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        doy_next   = doy_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    row_next = start_info.row;
                    doy_next = start_info.doy;
                    if (start_info.ok)
                    begin
                        state_next = ST_RD_CUR;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD_CUR:
            begin
                if (doy1 >= {3'd0, spring})
                begin
                    rem_next   = doy1 - {3'd0, spring};
                    idx_next   = 4'd1;
                    w_next     = rom_q;
                    state_next = ST_FWD;
                end
                else if (row_reg == '0)
                begin
                    // first table year before its new year: no prior word
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = {3'd0, spring} - doy1;
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV:
            begin
                w_next     = rom_q;
                idx_next   = (rom_q[23:20] != 4'd0) ? 4'd13 : 4'd12;
                state_next = ST_BWD;
            end
            ST_FWD:
            begin
                if (idx_reg < months && rem_reg >= {4'd0, len})
                begin
                    rem_next = rem_reg - {4'd0, len};
                    idx_next = idx_reg + 4'd1;
                end
                else
                begin
                    res_next   = map_month(w_reg, idx_reg, day_f);
                    state_next = ST_DONE;
                end
            end
            ST_BWD:
            begin
                if (idx_reg > 4'd1 && rem_reg > {4'd0, len})
                begin
                    rem_next = rem_reg - {4'd0, len};
                    idx_next = idx_reg - 4'd1;
                end
                else
                begin
                    res_next   = map_month(w_reg, idx_reg, day_b[4:0]);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        row_reg <= row_next;
        doy_reg <= doy_next;
        res_reg <= res_next;
    end

    // the previous year's word is fetched while the current one is examined
    assign rom_addr = (state_reg == ST_RD_CUR) ? row_reg - row_t'(1) : start_info.row;
    assign idle     = (state_reg == ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign result   = res_reg;

endmodule

`default_nettype wire

// ===== tb/sv/gregorian_to_chinese_lunar_date_test.sv =====
`timescale 1ns / 1ps

package g2l_test_pkg;

    localparam int FIRST_TABLE_YEAR = 1901;
    localparam int LAST_TABLE_YEAR  = 2099;

    // [23:20] leap month, [19:7] long/short flags of month sequence 1..13,
    // [6:5] New Year month (1 = January), [4:0] New Year day
    localparam logic [23:0] YEAR_WORDS [199] = '{
        24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
        24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
        24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
        24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
        24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
        24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
        24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
        24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
        24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
        24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
        24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
        24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
        24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
        24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
        24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
        24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
        24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
        24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
        24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
        24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
        24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
        24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
        24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
        24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
        24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
        24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
        24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
        24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
        24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
        24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
        24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
        24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
        24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
        24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
        24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
        24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
        24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
        24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
        24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
        24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
    };

    localparam int MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [3:0] lunar_month;
        logic [4:0] lunar_day;
        logic       intercalary;
    } lunar_date_t;

    typedef struct {
        logic [11:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
        lunar_date_t lunar;
    } conversion_t;

    // February always takes 29 days here
    function automatic int unsigned greg_month_days(input int unsigned mo);
        if (mo == 2)
            return 29;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            return 30;
        return 31;
    endfunction

    // idx is the lunar month sequence number 1..13
    function automatic int unsigned moon_days(input logic [23:0] word, input int unsigned idx);
        return word[20 - idx] ? 30 : 29;
    endfunction

    function automatic lunar_date_t to_lunar(input int unsigned yr, input int unsigned mo,
                                             input int unsigned dy);
        lunar_date_t lunar;
        logic [23:0] word;
        int unsigned row;
        int unsigned spring;
        int unsigned doy;
        int unsigned rem;
        int unsigned idx;
        int unsigned count;
        int unsigned leap;
        lunar = '0;
        if (yr < FIRST_TABLE_YEAR || yr > LAST_TABLE_YEAR || mo < 1 || mo > 12)
            return lunar;
        if (dy < 1 || dy > greg_month_days(mo))
            return lunar;
        row  = yr - FIRST_TABLE_YEAR;
        word = YEAR_WORDS[row];
        // New Year as a one-based day of year
        spring = word[4:0] + ((word[6:5] == 2'd1) ? 0 : 31);
        doy    = MONTH_OFFSET[mo - 1] + dy - 1 + ((yr % 4 == 0 && mo > 2) ? 1 : 0);
        if (doy + 1 >= spring)
        begin
            rem   = doy + 1 - spring;
            count = (word[23:20] != 0) ? 13 : 12;
            idx   = 1;
            while (idx < count && rem >= moon_days(word, idx))
            begin
                rem -= moon_days(word, idx);
                idx++;
            end
            lunar.lunar_day = 5'(rem + 1);
        end
        else
        begin
            // no word for the year before the table
            if (row == 0)
                return lunar;
            word = YEAR_WORDS[row - 1];
            rem  = spring - (doy + 1);
            idx  = (word[23:20] != 0) ? 13 : 12;
            while (idx > 1 && rem > moon_days(word, idx))
            begin
                rem -= moon_days(word, idx);
                idx--;
            end
            lunar.lunar_day = 5'(moon_days(word, idx) - rem + 1);
        end
        leap = word[23:20];
        if (leap == 0 || idx <= leap)
            lunar.lunar_month = 4'(idx);
        else if (idx == leap + 1)
        begin
            lunar.lunar_month = 4'(leap);
            lunar.intercalary = 1'b1;
        end
        else
            lunar.lunar_month = 4'(idx - 1);
        return lunar;
    endfunction

    class lunar_date_scoreboard;
        conversion_t expected_dates[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_date(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy);
            conversion_t conv;
            conv.greg_year  = yr;
            conv.greg_month = mo;
            conv.greg_day   = dy;
            conv.lunar      = to_lunar(yr, mo, dy);
            expected_dates.push_back(conv);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_date(input logic [15:0] data);
            conversion_t conv;
            lunar_date_t got;
            string       date;
            got.lunar_month = data[3:0];
            got.lunar_day   = data[8:4];
            got.intercalary = data[9];
            if (expected_dates.size() == 0)
            begin
                report($sformatf("result %h with no date outstanding", data));
                return;
            end
            conv = expected_dates.pop_front();
            date = $sformatf("%0d-%0d-%0d", conv.greg_year, conv.greg_month, conv.greg_day);
            if (got.lunar_month != conv.lunar.lunar_month)
                report($sformatf("%s lunar_month %0d, want %0d", date, got.lunar_month,
                                 conv.lunar.lunar_month));
            if (got.lunar_day != conv.lunar.lunar_day)
                report($sformatf("%s lunar_day %0d, want %0d", date, got.lunar_day,
                                 conv.lunar.lunar_day));
            if (got.intercalary != conv.lunar.intercalary)
                report($sformatf("%s intercalary %0d, want %0d", date, got.intercalary,
                                 conv.lunar.intercalary));
        endtask
    endclass

endpackage

module gregorian_to_chinese_lunar_date_test;
    import g2l_test_pkg::*;

    localparam int RANDOM_DATES = 900;
    localparam int STALL_LIMIT  = 1000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int idle_pct = 29;
    int quiet_cycles = 0;
    lunar_date_scoreboard board;

    gregorian_to_chinese_lunar_date i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // valid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_date(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, dy, mo, yr};
        do @(posedge clk); while (!s_tready);
        board.note_date(yr, mo, dy);
    endtask

    task automatic send_random_date();
        logic [11:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            // raw field noise, mostly invalid
            yr = 12'($urandom);
            mo = 4'($urandom);
            dy = 5'($urandom);
        end
        else
        begin
            yr = 12'($urandom_range(LAST_TABLE_YEAR, FIRST_TABLE_YEAR));
            // extra weight on January/February, around New Year
            mo = (pick < 40) ? 4'($urandom_range(2, 1)) : 4'($urandom_range(12, 1));
            dy = 5'($urandom_range(greg_month_days(mo), 1));
        end
        send_date(yr, mo, dy);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_date(m_tdata);
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int n;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_date(12'd0, 4'd1, 5'd1);
        send_date(12'd4095, 4'd15, 5'd31);
        send_date(12'd1900, 4'd6, 5'd15);
        send_date(12'd2100, 4'd1, 5'd1);
        // first table year, before and on its New Year
        send_date(12'd1901, 4'd1, 5'd1);
        send_date(12'd1901, 4'd2, 5'd18);
        send_date(12'd1901, 4'd2, 5'd19);
        // backward walks through the previous lunar year, then other edge and invalid dates
        send_date(12'd1902, 4'd1, 5'd1);
        send_date(12'd2000, 4'd1, 5'd1);
        send_date(12'd2099, 4'd12, 5'd31);
        send_date(12'd2000, 4'd0, 5'd10);
        send_date(12'd2000, 4'd13, 5'd1);
        send_date(12'd2000, 4'd3, 5'd0);
        send_date(12'd2001, 4'd4, 5'd31);
        send_date(12'd2001, 4'd1, 5'd31);
        // Feb 29 in a common year rolls into March 1
        send_date(12'd2001, 4'd2, 5'd29);
        send_date(12'd2000, 4'd2, 5'd29);
        send_date(12'd2000, 4'd2, 5'd30);
        // inside leap months, and just after one
        send_date(12'd2023, 4'd4, 5'd1);
        send_date(12'd2020, 4'd5, 5'd25);
        send_date(12'd2020, 4'd7, 5'd1);
        send_date(12'd2033, 4'd12, 5'd22);
        send_date(12'd1984, 4'd2, 5'd2);

        for (n = 0; n < RANDOM_DATES; n++)
        begin
            idle_pct = (n >= 300 && n < 450) ? 0 : 29;
            send_random_date();
        end
        s_tvalid <= 1'b0;
        idle_pct = 29;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/g2l_pkg.sv
hdl/g2l_rom.sv
hdl/g2l_walk.sv
hdl/gregorian_to_chinese_lunar_date.sv
tb/sv/gregorian_to_chinese_lunar_date_test.sv
